// File: rtl/psc_pkg.sv
// Shared constants and types of the plane segment clipper.
package psc_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int REG_IDX_W       = 3;
    localparam int NORMAL_Z_RESET  = 65536;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_BASE_X   = 3'd3,
        REG_BASE_Y   = 3'd4,
        REG_BASE_Z   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        CLS_PASS,
        CLS_REJECT,
        CLS_CROSS
    } seg_cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_DIV,
        ST_MUL,
        ST_SECOND
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/psc_queue.sv
// Short transaction queue between the classify front and the clip back end.
module psc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = psc_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    rd_data,
    output psc_pkg::q_status_t  status
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign rd_data      = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: rtl/psc_front.sv
// Front end: takes segments, forms both plane distances and classifies them.
module psc_front #(
    parameter int  COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF,
    localparam int PT_W        = 3 * COORD_WIDTH + 24,
    localparam int DIST_W      = 2 * COORD_WIDTH + 3,
    localparam int ENTRY_W     = 2 + 2 * PT_W + 2 * DIST_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [PT_W-1:0]                    a_pt,
    input  logic [PT_W-1:0]                    b_pt,
    input  logic [2:0][COORD_WIDTH-1:0]        normal,
    input  logic [2:0][COORD_WIDTH-1:0]        base,
    input  psc_pkg::q_status_t                 q_stat,
    output logic                               push,
    output logic [ENTRY_W-1:0]                 entry
);

    localparam int CW = COORD_WIDTH;

    typedef struct packed {
        logic [2:0][7:0]    k;
        logic [2:0][CW-1:0] c;
    } point_t;

    typedef struct packed {
        psc_pkg::seg_cls_t         cls;
        point_t                    first;
        point_t                    second;
        logic signed [DIST_W-1:0]  dp;
        logic signed [DIST_W-1:0]  dm;
    } entry_t;

    logic advance;
    logic accept;

    logic                 s1_v_reg, s2_v_reg, s3_v_reg;
    point_t               a_in, b_in;
    point_t               s1_a_reg, s1_b_reg, s2_a_reg, s2_b_reg;
    logic signed [CW:0]   da_next [3];
    logic signed [CW:0]   db_next [3];
    logic signed [CW:0]   s1_da_reg [3];
    logic signed [CW:0]   s1_db_reg [3];
    logic signed [2*CW:0] s2_pa_reg [3];
    logic signed [2*CW:0] s2_pb_reg [3];
    logic signed [DIST_W-1:0] dist_a, dist_b;
    logic                 a_neg, b_neg, a_pos, b_pos;
    entry_t               s3_next, s3_reg;

    assign a_in    = a_pt;
    assign b_in    = b_pt;
    assign advance = !(s3_v_reg && q_stat.full);
    assign busy    = !advance;
    assign accept  = start && advance;
    assign push    = s3_v_reg && !q_stat.full;
    assign entry   = s3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            da_next[i] = $signed({a_in.c[i][CW-1], a_in.c[i]})
                       - $signed({base[i][CW-1], base[i]});
            db_next[i] = $signed({b_in.c[i][CW-1], b_in.c[i]})
                       - $signed({base[i][CW-1], base[i]});
        end
    end

    always_comb
    begin
        dist_a = DIST_W'(s2_pa_reg[0]) + DIST_W'(s2_pa_reg[1]) + DIST_W'(s2_pa_reg[2]);
        dist_b = DIST_W'(s2_pb_reg[0]) + DIST_W'(s2_pb_reg[1]) + DIST_W'(s2_pb_reg[2]);
        a_neg  = dist_a[DIST_W-1];
        b_neg  = dist_b[DIST_W-1];
        a_pos  = !a_neg && (dist_a != '0);
        b_pos  = !b_neg && (dist_b != '0);

        s3_next.cls    = psc_pkg::CLS_PASS;
        s3_next.first  = s2_a_reg;
        s3_next.second = s2_b_reg;
        s3_next.dp     = dist_a;
        s3_next.dm     = dist_b;
        // put the endpoint in front of the plane first for a crossing
        priority if (a_neg && b_neg)
            s3_next.cls = psc_pkg::CLS_REJECT;
        else if (a_pos && b_neg)
            s3_next.cls = psc_pkg::CLS_CROSS;
        else if (a_neg && b_pos)
        begin
            s3_next.cls    = psc_pkg::CLS_CROSS;
            s3_next.first  = s2_b_reg;
            s3_next.second = s2_a_reg;
            s3_next.dp     = dist_b;
            s3_next.dm     = dist_a;
        end
        else
            s3_next.cls = psc_pkg::CLS_PASS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_a_reg <= a_in;
            s1_b_reg <= b_in;
            s2_a_reg <= s1_a_reg;
            s2_b_reg <= s1_b_reg;
            for (int i = 0; i < 3; i++)
            begin
                s1_da_reg[i] <= da_next[i];
                s1_db_reg[i] <= db_next[i];
                s2_pa_reg[i] <= s1_da_reg[i] * $signed(normal[i]);
                s2_pb_reg[i] <= s1_db_reg[i] * $signed(normal[i]);
            end
            s3_reg <= s3_next;
        end
    end

endmodule

// File: rtl/psc_back.sv
// Back end: emits endpoints and moves the far endpoint onto the plane.
module psc_back #(
    parameter int  COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF,
    parameter int  FRAC_BITS   = psc_pkg::FRAC_BITS_DEF,
    localparam int PT_W        = 3 * COORD_WIDTH + 24,
    localparam int DIST_W      = 2 * COORD_WIDTH + 3,
    localparam int ENTRY_W     = 2 + 2 * PT_W + 2 * DIST_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psc_pkg::q_status_t   q_stat,
    input  logic [ENTRY_W-1:0]   entry,
    output logic                 pop,
    output logic [PT_W-1:0]      out_pt,
    output logic                 rejected,
    output logic                 last,
    output logic                 done
);

    localparam int CW    = COORD_WIDTH;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int DEN_W = DIST_W + 1;
    localparam int PW    = CW + 1 + FRAC_BITS;
    localparam int KW    = 9 + FRAC_BITS;

    typedef struct packed {
        logic [2:0][7:0]    k;
        logic [2:0][CW-1:0] c;
    } point_t;

    typedef struct packed {
        psc_pkg::seg_cls_t         cls;
        point_t                    first;
        point_t                    second;
        logic signed [DIST_W-1:0]  dp;
        logic signed [DIST_W-1:0]  dm;
    } entry_t;

    psc_pkg::back_state_t state_reg, state_next;

    entry_t               ent_in, ent_reg;
    logic                 emit_first, emit_second, div_step, mul_go;
    logic [DEN_W-1:0]     den_reg, rem_reg, rem_dbl, den_next;
    logic                 rem_ge;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic signed [CW:0]   cdelta [3];
    logic signed [8:0]    kdelta [3];
    logic [CW:0]          cmag_reg [3];
    logic [8:0]           kmag_reg [3];
    logic [2:0]           cneg_reg, kneg_reg;
    logic [PW-1:0]        cprod_reg [3];
    logic [KW-1:0]        kprod_reg [3];
    logic [CW:0]          cstep [3];
    logic [8:0]           kstep [3];
    point_t               moved;
    point_t               out_pt_reg;
    logic                 rej_reg, last_reg, done_reg;

    assign ent_in   = entry;
    assign out_pt   = out_pt_reg;
    assign rejected = rej_reg;
    assign last     = last_reg;
    assign done     = done_reg;

    always_comb
    begin
        pop         = 1'b0;
        emit_first  = 1'b0;
        emit_second = 1'b0;
        div_step    = 1'b0;
        mul_go      = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    state_next = psc_pkg::ST_FIRST;
                end
            end
            psc_pkg::ST_FIRST:
            begin
                emit_first = 1'b1;
                unique case (ent_reg.cls)
                    psc_pkg::CLS_REJECT:
                    begin
                        pop        = !q_stat.empty;
                        state_next = q_stat.empty ? psc_pkg::ST_IDLE : psc_pkg::ST_FIRST;
                    end
                    psc_pkg::CLS_CROSS:
                        state_next = psc_pkg::ST_DIV;
                    default:
                        state_next = psc_pkg::ST_SECOND;
                endcase
            end
            psc_pkg::ST_DIV:
            begin
                div_step = 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = psc_pkg::ST_MUL;
            end
            psc_pkg::ST_MUL:
            begin
                mul_go     = 1'b1;
                state_next = psc_pkg::ST_SECOND;
            end
            psc_pkg::ST_SECOND:
            begin
                emit_second = 1'b1;
                pop         = !q_stat.empty;
                state_next  = q_stat.empty ? psc_pkg::ST_IDLE : psc_pkg::ST_FIRST;
            end
            default:
                state_next = psc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        den_next = $signed({ent_reg.dp[DIST_W-1], ent_reg.dp})
                 - $signed({ent_reg.dm[DIST_W-1], ent_reg.dm});
        rem_dbl  = {rem_reg[DEN_W-2:0], 1'b0};
        rem_ge   = (rem_dbl >= den_reg);
        for (int i = 0; i < 3; i++)
        begin
            cdelta[i] = $signed({ent_reg.second.c[i][CW-1], ent_reg.second.c[i]})
                      - $signed({ent_reg.first.c[i][CW-1], ent_reg.first.c[i]});
            kdelta[i] = $signed({1'b0, ent_reg.second.k[i]})
                      - $signed({1'b0, ent_reg.first.k[i]});
            // truncate toward zero: scale the magnitude, then restore the sign
            cstep[i]  = cneg_reg[i] ? -cprod_reg[i][PW-1:FRAC_BITS]
                                    : cprod_reg[i][PW-1:FRAC_BITS];
            kstep[i]  = kneg_reg[i] ? -kprod_reg[i][KW-1:FRAC_BITS]
                                    : kprod_reg[i][KW-1:FRAC_BITS];
            moved.c[i] = ent_reg.first.c[i] + cstep[i][CW-1:0];
            moved.k[i] = ent_reg.first.k[i] + kstep[i][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psc_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit_first || emit_second;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            ent_reg <= ent_in;
        if (emit_first)
        begin
            den_reg <= den_next;
            rem_reg <= DEN_W'(ent_reg.dp);
            quo_reg <= '0;
            cnt_reg <= CNT_W'(FRAC_BITS);
            for (int i = 0; i < 3; i++)
            begin
                cneg_reg[i] <= cdelta[i][CW];
                cmag_reg[i] <= cdelta[i][CW] ? -cdelta[i] : cdelta[i];
                kneg_reg[i] <= kdelta[i][8];
                kmag_reg[i] <= kdelta[i][8] ? -kdelta[i] : kdelta[i];
            end
            if (ent_reg.cls == psc_pkg::CLS_REJECT)
            begin
                out_pt_reg <= '0;
                rej_reg    <= 1'b1;
                last_reg   <= 1'b1;
            end
            else
            begin
                out_pt_reg <= ent_reg.first;
                rej_reg    <= 1'b0;
                last_reg   <= 1'b0;
            end
        end
        if (div_step)
        begin
            rem_reg <= rem_ge ? rem_dbl - den_reg : rem_dbl;
            quo_reg <= {quo_reg[FRAC_BITS-2:0], rem_ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (mul_go)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cprod_reg[i] <= PW'(cmag_reg[i]) * PW'(quo_reg);
                kprod_reg[i] <= KW'(kmag_reg[i]) * KW'(quo_reg);
            end
        end
        if (emit_second)
        begin
            out_pt_reg <= (ent_reg.cls == psc_pkg::CLS_CROSS) ? moved : ent_reg.second;
            rej_reg    <= 1'b0;
            last_reg   <= 1'b1;
        end
    end

endmodule

// File: rtl/plane_segment_clipper.sv
// Top level of the plane segment clipper: configuration registers and the two halves.
//
// Usage: write the plane normal and base point through wr_en / wr_index / wr_data while
// the block is idle. A segment transaction is taken at a clock edge where start is high
// and busy is low. Each segment gives two endpoint results, or one result with rejected
// set when both endpoints lie behind the plane; last marks the final result of a segment.
// Each result is on the out_* ports for one cycle with done high; it cannot be held off.
// A segment passes the front pipeline, the queue and the back end's entry register before
// its first result is registered on the out_* ports.
// The back end pops the next segment as it emits the last result of the current one.
// A segment that crosses the plane is held in the back end while the bit-serial divider
// forms the crossing fraction; the queue between front and back keeps accepting segments
// meanwhile, and busy rises only once the queue is full.
// Reset clears the pipeline and queue, and loads the plane normal (0, 0, 1.0) and base 0.
module plane_segment_clipper #(
    parameter int FRAC_BITS   = psc_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [psc_pkg::REG_IDX_W-1:0]       wr_index,
    input  logic [COORD_WIDTH-1:0]              wr_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [COORD_WIDTH-1:0]              a_x,
    input  logic [COORD_WIDTH-1:0]              a_y,
    input  logic [COORD_WIDTH-1:0]              a_z,
    input  logic [7:0]                          a_red,
    input  logic [7:0]                          a_green,
    input  logic [7:0]                          a_blue,
    input  logic [COORD_WIDTH-1:0]              b_x,
    input  logic [COORD_WIDTH-1:0]              b_y,
    input  logic [COORD_WIDTH-1:0]              b_z,
    input  logic [7:0]                          b_red,
    input  logic [7:0]                          b_green,
    input  logic [7:0]                          b_blue,
    output logic                                done,
    output logic [COORD_WIDTH-1:0]              out_x,
    output logic [COORD_WIDTH-1:0]              out_y,
    output logic [COORD_WIDTH-1:0]              out_z,
    output logic [7:0]                          out_red,
    output logic [7:0]                          out_green,
    output logic [7:0]                          out_blue,
    output logic                                rejected,
    output logic                                last
);

    localparam int CW      = COORD_WIDTH;
    localparam int PT_W    = 3 * CW + 24;
    localparam int DIST_W  = 2 * CW + 3;
    localparam int ENTRY_W = 2 + 2 * PT_W + 2 * DIST_W;

    logic [2:0][CW-1:0]  normal_reg;
    logic [2:0][CW-1:0]  base_reg;
    logic                q_push, q_pop;
    logic [ENTRY_W-1:0]  q_wr_data, q_rd_data;
    psc_pkg::q_status_t  q_stat;
    logic [PT_W-1:0]     res_pt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg <= {CW'(psc_pkg::NORMAL_Z_RESET), CW'(0), CW'(0)};
            base_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                psc_pkg::REG_NORMAL_X: normal_reg[0] <= wr_data;
                psc_pkg::REG_NORMAL_Y: normal_reg[1] <= wr_data;
                psc_pkg::REG_NORMAL_Z: normal_reg[2] <= wr_data;
                psc_pkg::REG_BASE_X:   base_reg[0]   <= wr_data;
                psc_pkg::REG_BASE_Y:   base_reg[1]   <= wr_data;
                psc_pkg::REG_BASE_Z:   base_reg[2]   <= wr_data;
                default: ;
            endcase
        end
    end

    psc_front #(
        .COORD_WIDTH (CW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .a_pt   ({a_blue, a_green, a_red, a_z, a_y, a_x}),
        .b_pt   ({b_blue, b_green, b_red, b_z, b_y, b_x}),
        .normal (normal_reg),
        .base   (base_reg),
        .q_stat (q_stat),
        .push   (q_push),
        .entry  (q_wr_data)
    );

    psc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (psc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_stat)
    );

    psc_back #(
        .COORD_WIDTH (CW),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .entry    (q_rd_data),
        .pop      (q_pop),
        .out_pt   (res_pt),
        .rejected (rejected),
        .last     (last),
        .done     (done)
    );

    assign out_x     = res_pt[CW-1:0];
    assign out_y     = res_pt[2*CW-1:CW];
    assign out_z     = res_pt[3*CW-1:2*CW];
    assign out_red   = res_pt[3*CW+7:3*CW];
    assign out_green = res_pt[3*CW+15:3*CW+8];
    assign out_blue  = res_pt[3*CW+23:3*CW+16];

    a_reject_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rejected) |-> (last && out_x == '0 && out_z == '0 && out_red == '0))
        else $error("rejected result without last or with nonzero fields");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

endmodule
